// ===== rtl/lrgf_pkg.sv =====
// ----------------------------------------------------------------------------
// lrgf_pkg: shared types and constants for the latching relay controller
// Reset defaults of the setup registers, register indexes and the result
// record that travels from the state machine to the output ports.
// ----------------------------------------------------------------------------
`default_nettype none

package lrgf_pkg;

    localparam int TIMER_BITS_DEFAULT = 20;

    // setup port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int DUR_REG_W   = 20;
    localparam int LIMIT_W     = 8;
    localparam int TALLY_W     = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_TICKS       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_DELAY_TICKS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROBATION_TICKS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAULT_LIMIT       = 3'd3;

    // defaults assume a 1 ms tick
    localparam logic [DUR_REG_W-1:0] PULSE_TICKS_RST       = 20'd150;
    localparam logic [DUR_REG_W-1:0] FAULT_DELAY_TICKS_RST = 20'd15000;
    localparam logic [DUR_REG_W-1:0] PROBATION_TICKS_RST   = 20'd10000;
    localparam logic [LIMIT_W-1:0]   FAULT_LIMIT_RST       = 8'd20;

    typedef struct packed {
        logic               set_coil;
        logic               reset_coil;
        logic [2:0]         mode_code;
        logic [TALLY_W-1:0] faults_seen;
        logic               locked_out;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/latching_relay_ground_fault_fsm.sv =====
// a request waits in the input register, then its result is registered in
// the result register behind m_valid; throughput is one request per cycle
// while m_ready is high; a stalled result holds one more request in the
// input register, after which s_ready stays low until m_ready returns
// reset: synchronous active-low aresetn clears state, the fault tally, the
// valid flags and restores the setup register defaults
// ----------------------------------------------------------------------------
// latching_relay_ground_fault_fsm: latching relay controller, top level
// Input register, relay state machine with result register, setup registers
// and the valid/ready flow control around them.
// ----------------------------------------------------------------------------
`default_nettype none

module latching_relay_ground_fault_fsm
    import lrgf_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    // setup port
    input  wire                    cfg_wen,
    input  wire [CFG_INDEX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_wdata,
    // tick requests in
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire                    s_request_a,
    input  wire                    s_request_b,
    input  wire                    s_ground_fault,
    // results out
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic                   m_set_coil,
    output logic                   m_reset_coil,
    output logic [2:0]             m_mode_code,
    output logic [TALLY_W-1:0]     m_faults_seen,
    output logic                   m_locked_out
);

    logic [TIMER_BITS-1:0] pulse_ticks;
    logic [TIMER_BITS-1:0] fault_delay_ticks;
    logic [TIMER_BITS-1:0] probation_ticks;
    logic [LIMIT_W-1:0]    trip_limit;

    // input register
    logic in_vld_reg, in_vld_next;
    logic req_a_reg, req_b_reg, gf_reg;

    // output handshake
    logic m_valid_reg, m_valid_next;

    logic adv;
    logic s_fire;
    res_t res;

    // the held request moves into the state machine whenever the result
    // register is free or being drained this cycle
    assign adv    = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;
    assign s_fire = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (adv) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload of the held request, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_a_reg <= s_request_a;
            req_b_reg <= s_request_b;
            gf_reg    <= s_ground_fault;
        end
    end

    lrgf_cfg_regs #(
        .TIMER_BITS (TIMER_BITS)
    ) u_cfg (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wen           (cfg_wen),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .pulse_ticks       (pulse_ticks),
        .fault_delay_ticks (fault_delay_ticks),
        .probation_ticks   (probation_ticks),
        .trip_limit        (trip_limit)
    );

    lrgf_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .adv               (adv),
        .request_a         (req_a_reg),
        .request_b         (req_b_reg),
        .ground_fault      (gf_reg),
        .pulse_ticks       (pulse_ticks),
        .fault_delay_ticks (fault_delay_ticks),
        .probation_ticks   (probation_ticks),
        .trip_limit        (trip_limit),
        .res               (res)
    );

    // result fields straight from the result register
    assign m_valid       = m_valid_reg;
    assign m_set_coil    = res.set_coil;
    assign m_reset_coil  = res.reset_coil;
    assign m_mode_code   = res.mode_code;
    assign m_faults_seen = res.faults_seen;
    assign m_locked_out  = res.locked_out;

endmodule

`default_nettype wire

// ===== rtl/lrgf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lrgf_cfg_regs: setup registers
// Pulse length, fault wait, probation window and fault limit, written through
// a plain write port; durations are kept at the timer width.
// ----------------------------------------------------------------------------
`default_nettype none

module lrgf_cfg_regs
    import lrgf_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_wen,
    input  wire [CFG_INDEX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_wdata,
    output logic [TIMER_BITS-1:0]  pulse_ticks,
    output logic [TIMER_BITS-1:0]  fault_delay_ticks,
    output logic [TIMER_BITS-1:0]  probation_ticks,
    output logic [LIMIT_W-1:0]     trip_limit
);

    localparam int DUR_W = (TIMER_BITS < DUR_REG_W) ? TIMER_BITS : DUR_REG_W;

    logic [TIMER_BITS-1:0] pulse_reg;
    logic [TIMER_BITS-1:0] delay_reg;
    logic [TIMER_BITS-1:0] prob_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [TIMER_BITS-1:0] wdata_dur;

    // keep the bits both the register and the timer can hold
    assign wdata_dur = TIMER_BITS'(cfg_wdata[DUR_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg <= TIMER_BITS'(PULSE_TICKS_RST[DUR_W-1:0]);
            delay_reg <= TIMER_BITS'(FAULT_DELAY_TICKS_RST[DUR_W-1:0]);
            prob_reg  <= TIMER_BITS'(PROBATION_TICKS_RST[DUR_W-1:0]);
            limit_reg <= FAULT_LIMIT_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_PULSE_TICKS:       pulse_reg <= wdata_dur;
                CFG_FAULT_DELAY_TICKS: delay_reg <= wdata_dur;
                CFG_PROBATION_TICKS:   prob_reg  <= wdata_dur;
                CFG_FAULT_LIMIT:       limit_reg <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign pulse_ticks       = pulse_reg;
    assign fault_delay_ticks = delay_reg;
    assign probation_ticks   = prob_reg;
    assign trip_limit        = limit_reg;

endmodule

`default_nettype wire

// ===== rtl/lrgf_core.sv =====
// ----------------------------------------------------------------------------
// lrgf_core: relay state machine
// One tick per advance: updates mode, pulse phase, tick timer and fault tally
// and registers the result record that shows the state after the update.
// ----------------------------------------------------------------------------
`default_nettype none

module lrgf_core
    import lrgf_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   adv,
    input  wire                   request_a,
    input  wire                   request_b,
    input  wire                   ground_fault,
    input  wire [TIMER_BITS-1:0]  pulse_ticks,
    input  wire [TIMER_BITS-1:0]  fault_delay_ticks,
    input  wire [TIMER_BITS-1:0]  probation_ticks,
    input  wire [LIMIT_W-1:0]     trip_limit,
    output res_t                  res
);

    typedef enum logic [2:0] {
        MODE_OFF       = 3'd0,
        MODE_ENABLING  = 3'd1,
        MODE_ON        = 3'd2,
        MODE_DISABLING = 3'd3,
        MODE_SOFT      = 3'd4,
        MODE_LOCK      = 3'd5,
        MODE_PROBATION = 3'd6
    } mode_t;

    mode_t                 mode_reg, mode_next, fault_mode;
    logic                  phase_reg, phase_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next, tick_inc;
    logic [TALLY_W-1:0]    tally_reg, tally_next, tally_sat;
    res_t                  res_reg, res_next;
    logic                  want;

    assign want      = request_a && request_b;
    assign tick_inc  = tick_reg + 1'b1;
    assign tally_sat = (tally_reg == {TALLY_W{1'b1}}) ? tally_reg : tally_reg + 1'b1;
    assign fault_mode = (tally_sat >= trip_limit) ? MODE_LOCK : MODE_SOFT;

    always_comb begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        tally_next = tally_reg;
        unique case (mode_reg) inside
            MODE_ENABLING, MODE_DISABLING: begin
                if (ground_fault) begin
                    tally_next = tally_sat;
                    mode_next  = fault_mode;
                    phase_next = 1'b0;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_inc;
                    if (tick_inc >= pulse_ticks) begin
                        tick_next  = '0;
                        phase_next = 1'b0;
                        if (!phase_reg) begin
                            phase_next = 1'b1;
                        end else if (mode_reg == MODE_DISABLING) begin
                            mode_next = MODE_OFF;
                        end else begin
                            mode_next = (tally_reg == '0) ? MODE_ON : MODE_PROBATION;
                        end
                    end
                end
            end
            MODE_ON: begin
                if (!want) begin
                    mode_next  = MODE_DISABLING;
                    phase_next = 1'b0;
                    tick_next  = '0;
                end else if (ground_fault) begin
                    tally_next = tally_sat;
                    mode_next  = fault_mode;
                    phase_next = 1'b0;
                    tick_next  = '0;
                end
            end
            MODE_SOFT: begin
                tick_next = tick_inc;
                if (tick_inc >= fault_delay_ticks) begin
                    mode_next  = MODE_ENABLING;
                    phase_next = 1'b0;
                    tick_next  = '0;
                end
            end
            MODE_LOCK: ;
            MODE_PROBATION: begin
                if (!want) begin
                    tally_next = '0;
                    mode_next  = MODE_DISABLING;
                    phase_next = 1'b0;
                    tick_next  = '0;
                end else if (ground_fault) begin
                    tally_next = tally_sat;
                    mode_next  = fault_mode;
                    phase_next = 1'b0;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_inc;
                    if (tick_inc >= probation_ticks) begin
                        tally_next = '0;
                        mode_next  = MODE_ON;
                        phase_next = 1'b0;
                        tick_next  = '0;
                    end
                end
            end
            default: begin
                // off, and the unused code taken as off
                mode_next = MODE_OFF;
                if (want) begin
                    mode_next  = MODE_ENABLING;
                    phase_next = 1'b0;
                    tick_next  = '0;
                end
            end
        endcase
    end

    always_comb begin
        res_next.set_coil    = ((mode_next == MODE_ENABLING) && phase_next) ||
                               ((mode_next == MODE_DISABLING) && !phase_next);
        res_next.reset_coil  = ((mode_next == MODE_ENABLING) && !phase_next) ||
                               ((mode_next == MODE_DISABLING) && phase_next);
        res_next.mode_code   = mode_next;
        res_next.faults_seen = tally_next;
        res_next.locked_out  = (mode_next == MODE_LOCK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_OFF;
            phase_reg <= 1'b0;
            tick_reg  <= '0;
            tally_reg <= '0;
        end else if (adv) begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            tally_reg <= tally_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

    // lockout is left only by reset
    a_lock_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_LOCK) |=> (mode_reg == MODE_LOCK))
        else $error("lockout left without reset");

    // plain on state only with a clear tally
    a_on_clear_tally: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_ON) |-> (tally_reg == '0))
        else $error("on with nonzero fault tally");

    // result record tracks the state it was built from
    a_res_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(adv) |-> (res_reg.mode_code == mode_reg &&
                        res_reg.faults_seen == tally_reg))
        else $error("result out of step with state");

    a_coils_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(adv) |-> !(res_reg.set_coil && res_reg.reset_coil))
        else $error("both coils driven");

    a_timer_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(tick_reg))
        else $error("timer moved without a tick");

endmodule

`default_nettype wire

// ===== sim/lrgf_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrgf_tb_pkg: relay controller scoreboard
// Tracks the relay state machine one tick at a time, queues the expected
// result of every accepted request and compares delivered results with it.
// ----------------------------------------------------------------------------

package lrgf_tb_pkg;

    import lrgf_pkg::*;

    typedef enum logic [2:0] {
        MODE_OFF        = 3'd0,
        MODE_ENABLING   = 3'd1,
        MODE_ON         = 3'd2,
        MODE_DISABLING  = 3'd3,
        MODE_SOFT_FAULT = 3'd4,
        MODE_LOCKOUT    = 3'd5,
        MODE_PROBATION  = 3'd6
    } relay_mode_e;

    localparam int TB_TIMER_W = TIMER_BITS_DEFAULT;
    localparam int MAX_PRINTED = 40;

    class relay_scoreboard;

        // settings
        logic [TB_TIMER_W-1:0] pulse_len;
        logic [TB_TIMER_W-1:0] retry_wait;
        logic [TB_TIMER_W-1:0] probation_len;
        logic [LIMIT_W-1:0]    fault_cap;

        // relay state
        relay_mode_e           relay_mode;
        bit                    second_pulse;
        logic [TB_TIMER_W-1:0] tick_cnt;
        logic [TALLY_W-1:0]    fault_tally;

        res_t expected_results[$];
        int   errors;
        int   ticks_noted;
        int   results_checked;
        int   mode_hits[8];

        function new();
            pulse_len     = TB_TIMER_W'(PULSE_TICKS_RST);
            retry_wait    = TB_TIMER_W'(FAULT_DELAY_TICKS_RST);
            probation_len = TB_TIMER_W'(PROBATION_TICKS_RST);
            fault_cap     = FAULT_LIMIT_RST;
            fault_tally   = '0;
            enter_mode(MODE_OFF);
        endfunction

        function void write_setting(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PULSE_TICKS:       pulse_len = TB_TIMER_W'(data);
                CFG_FAULT_DELAY_TICKS: retry_wait = TB_TIMER_W'(data);
                CFG_PROBATION_TICKS:   probation_len = TB_TIMER_W'(data);
                CFG_FAULT_LIMIT:       fault_cap = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void enter_mode(relay_mode_e m);
            relay_mode   = m;
            second_pulse = 1'b0;
            tick_cnt     = '0;
        endfunction

        // a zero length expires on the first tick as well
        function bit timer_expired(logic [TB_TIMER_W-1:0] span);
            tick_cnt = tick_cnt + 1'b1;
            return tick_cnt >= span;
        endfunction

        function void count_fault();
            if (fault_tally != '1)
                fault_tally = fault_tally + 1'b1;
            if (fault_tally >= fault_cap)
                enter_mode(MODE_LOCKOUT);
            else
                enter_mode(MODE_SOFT_FAULT);
        endfunction

        function void note_tick(bit request_a, bit request_b, bit ground_fault);
            bit   want;
            res_t r;
            want = request_a && request_b;
            case (relay_mode)
                MODE_ENABLING, MODE_DISABLING: begin
                    if (ground_fault) begin
                        count_fault();
                    end else if (timer_expired(pulse_len)) begin
                        if (!second_pulse) begin
                            second_pulse = 1'b1;
                            tick_cnt = '0;
                        end else if (relay_mode == MODE_DISABLING) begin
                            enter_mode(MODE_OFF);
                        end else if (fault_tally == '0) begin
                            enter_mode(MODE_ON);
                        end else begin
                            enter_mode(MODE_PROBATION);
                        end
                    end
                end
                MODE_ON: begin
                    if (!want)
                        enter_mode(MODE_DISABLING);
                    else if (ground_fault)
                        count_fault();
                end
                MODE_SOFT_FAULT: begin
                    if (timer_expired(retry_wait))
                        enter_mode(MODE_ENABLING);
                end
                MODE_LOCKOUT: ;
                MODE_PROBATION: begin
                    if (!want) begin
                        fault_tally = '0;
                        enter_mode(MODE_DISABLING);
                    end else if (ground_fault) begin
                        count_fault();
                    end else if (timer_expired(probation_len)) begin
                        fault_tally = '0;
                        enter_mode(MODE_ON);
                    end
                end
                default: begin
                    relay_mode = MODE_OFF;
                    if (want)
                        enter_mode(MODE_ENABLING);
                end
            endcase

            r = '0;
            if (relay_mode == MODE_ENABLING) begin
                r.reset_coil = !second_pulse;
                r.set_coil   = second_pulse;
            end else if (relay_mode == MODE_DISABLING) begin
                r.set_coil   = !second_pulse;
                r.reset_coil = second_pulse;
            end
            r.mode_code   = relay_mode;
            r.faults_seen = fault_tally;
            r.locked_out  = (relay_mode == MODE_LOCKOUT);
            expected_results.push_back(r);
            ticks_noted++;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string field, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                          results_checked, field, got, want));
        endtask

        task check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            want = expected_results.pop_front();
            compare_field("set_coil", 8'(got.set_coil), 8'(want.set_coil));
            compare_field("reset_coil", 8'(got.reset_coil), 8'(want.reset_coil));
            compare_field("mode_code", 8'(got.mode_code), 8'(want.mode_code));
            compare_field("faults_seen", got.faults_seen, want.faults_seen);
            compare_field("locked_out", 8'(got.locked_out), 8'(want.locked_out));
            mode_hits[want.mode_code]++;
            results_checked++;
        endtask

        function string mode_summary();
            string       line;
            relay_mode_e md;
            line = "results per mode:";
            for (int m = 0; m <= int'(MODE_PROBATION); m++) begin
                md = relay_mode_e'(m);
                line = {line, $sformatf(" %s=%0d", md.name(), mode_hits[m])};
            end
            return line;
        endfunction

    endclass

endpackage

// ===== sim/latching_relay_ground_fault_fsm_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latching_relay_ground_fault_fsm_tb: relay controller testbench
// Feeds tick requests (two request lines and a ground fault flag) through
// the block, tracks the relay state machine in a scoreboard and checks
// every result field. A directed opening walks the enable, probation,
// disable and fault paths, then random setup phases run random request
// traffic with random gaps on both sides, ending in a lockout.
// ----------------------------------------------------------------------------

module latching_relay_ground_fault_fsm_tb;

    import lrgf_pkg::*;
    import lrgf_tb_pkg::*;

    localparam logic [CFG_DATA_W-1:0] DUR_MAX = '1;
    localparam logic [LIMIT_W-1:0]    LIMIT_MAX = '1;
    localparam int SETTLE_CYCLES = 4;       // a result passes the input register, then the result register
    localparam int IDLE_PCT = 36;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_request_a = 1'b0;
    logic                   s_request_b = 1'b0;
    logic                   s_ground_fault = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_set_coil;
    logic                   m_reset_coil;
    logic [2:0]             m_mode_code;
    logic [TALLY_W-1:0]     m_faults_seen;
    logic                   m_locked_out;

    res_t seen_result;

    relay_scoreboard sb = new();

    int src_idle_pct = IDLE_PCT;
    int sink_idle_pct = IDLE_PCT;
    int setup_phases = 0;
    bit want_level = 1'b0;              // random traffic: requesters asking for power

    latching_relay_ground_fault_fsm dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_request_a    (s_request_a),
        .s_request_b    (s_request_b),
        .s_ground_fault (s_ground_fault),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_set_coil     (m_set_coil),
        .m_reset_coil   (m_reset_coil),
        .m_mode_code    (m_mode_code),
        .m_faults_seen  (m_faults_seen),
        .m_locked_out   (m_locked_out)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    assign seen_result = {m_set_coil, m_reset_coil, m_mode_code, m_faults_seen, m_locked_out};

    // result side: check on every accepted result, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(seen_result);
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // one tick request; valid stays up across back-to-back requests
    task send_tick(bit request_a, bit request_b, bit ground_fault);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_request_a    <= request_a;
        s_request_b    <= request_b;
        s_ground_fault <= ground_fault;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_tick(request_a, request_b, ground_fault);
    endtask

    task hold(bit request_a, bit request_b, bit ground_fault, int n);
        repeat (n) send_tick(request_a, request_b, ground_fault);
    endtask

    // random traffic: long stretches of wanted power, occasional drops,
    // a little noise on the request lines and faults at the given rate
    task random_ticks(int n, int fault_pct);
        bit a;
        bit b;
        bit gf;
        repeat (n) begin
            if ($urandom_range(0, 99) < 5)
                want_level = !want_level;
            if (want_level) begin
                a = 1'b1;
                b = 1'b1;
            end else begin
                {a, b} = 2'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 99) < 4)
                {a, b} = 2'($urandom);
            gf = ($urandom_range(0, 99) < fault_pct);
            send_tick(a, b, gf);
        end
    endtask

    // stop sending and let every outstanding result come back
    task drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_cycle(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_setting(idx, data);
    endtask

    // all four registers back to back; upper data bits of the limit write
    // are junk, and optionally the unused indexes get junk writes too
    task program_setup(logic [CFG_DATA_W-1:0] pulse, logic [CFG_DATA_W-1:0] retry,
                       logic [CFG_DATA_W-1:0] probation, logic [LIMIT_W-1:0] cap,
                       bit hit_unused);
        logic [31:0] junk;
        junk = $urandom;
        write_cycle(CFG_PULSE_TICKS, pulse);
        write_cycle(CFG_FAULT_DELAY_TICKS, retry);
        write_cycle(CFG_PROBATION_TICKS, probation);
        write_cycle(CFG_FAULT_LIMIT, {junk[CFG_DATA_W-LIMIT_W-1:0], cap});
        if (hit_unused) begin
            for (int k = int'(CFG_FAULT_LIMIT) + 1; k < 2 ** CFG_INDEX_W; k++)
                write_cycle(CFG_INDEX_W'(k), CFG_DATA_W'($urandom));
        end
        cfg_wen <= 1'b0;
        setup_phases++;
    endtask

    initial begin : stimulus
        logic [LIMIT_W-1:0] cap;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: half requests stay off, gf ignored on the enabling
        // tick, a fault on the next tick aborts into a long soft fault wait
        hold(1'b1, 1'b0, 1'b1, 1);
        hold(1'b0, 1'b1, 1'b0, 1);
        hold(1'b1, 1'b1, 1'b1, 2);
        drain();

        // short timings, junk on the unused indexes; the new retry wait
        // releases the soft fault left over from the defaults
        program_setup(20'd1, 20'd2, 20'd3, LIMIT_MAX, 1'b1);
        hold(1'b1, 1'b1, 1'b0, 4);          // retry, both pulses, probation
        hold(1'b1, 1'b1, 1'b1, 1);          // fault in probation
        hold(1'b0, 1'b0, 1'b0, 4);          // retry ignores requests, probation again
        hold(1'b0, 1'b1, 1'b1, 1);          // drop beats fault, tally clears
        hold(1'b1, 1'b1, 1'b0, 5);          // disable finishes, enable, on
        hold(1'b1, 1'b0, 1'b1, 1);          // drop beats fault while on
        hold(1'b1, 1'b1, 1'b1, 1);          // fault during a disabling pulse
        hold(1'b1, 1'b1, 1'b0, 7);          // retry, probation runs out, on
        hold(1'b1, 1'b1, 1'b1, 1);          // fault while on
        drain();

        // zero durations act as one tick
        program_setup('0, '0, '0, LIMIT_MAX, 1'b0);
        random_ticks(20, 10);
        hold(1'b0, 1'b0, 1'b0, 6);
        drain();

        // longest probation window, left early by a dropped request
        program_setup(20'd2, 20'd2, DUR_MAX, LIMIT_MAX, 1'b0);
        hold(1'b1, 1'b1, 1'b0, 6);
        hold(1'b1, 1'b1, 1'b1, 1);
        hold(1'b1, 1'b1, 1'b0, 12);
        hold(1'b1, 1'b0, 1'b0, 2);
        hold(1'b0, 1'b0, 1'b0, 6);
        drain();

        // longest pulse cut short by a fault, then the longest retry wait;
        // the next setup phase shortens the wait and lets it go
        program_setup(DUR_MAX, DUR_MAX, 20'd3, LIMIT_MAX, 1'b0);
        hold(1'b1, 1'b1, 1'b0, 4);
        hold(1'b1, 1'b1, 1'b1, 1);
        hold(1'b1, 1'b1, 1'b0, 5);
        drain();

        // random setup phases; one with no gaps on either side and one with
        // a mid-phase pause until the result queue is empty
        for (int ph = 0; ph < 6; ph++) begin
            if ($urandom_range(0, 1))
                cap = LIMIT_MAX;
            else
                cap = LIMIT_W'($urandom_range(40, 254));
            program_setup(CFG_DATA_W'($urandom_range(1, 5)), CFG_DATA_W'($urandom_range(1, 10)),
                          CFG_DATA_W'($urandom_range(1, 25)), cap, ph == 0);
            src_idle_pct  = (ph == 2) ? 0 : IDLE_PCT;
            sink_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
            random_ticks(60, $urandom_range(2, 6));
            if (ph == 3)
                drain();
            random_ticks(60, $urandom_range(2, 6));
            drain();
        end

        // low fault limit (zero included) and heavy faults: ends in lockout
        program_setup(CFG_DATA_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom_range(1, 4)),
                      20'd20, LIMIT_W'($urandom_range(0, 4)), 1'b0);
        random_ticks(120, 25);
        drain();

        // anything arriving now is unexpected and gets flagged by the checker
        repeat (8) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("covered %0d tick requests over %0d setup phases, %0d results checked",
                 sb.ticks_noted, setup_phases, sb.results_checked);
        $display("%s", sb.mode_summary());
        if (sb.errors == 0) begin
            $display("latching_relay_ground_fault_fsm test passed");
        end else begin
            $display("latching_relay_ground_fault_fsm test failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("latching_relay_ground_fault_fsm test failed");
        $finish;
    end

endmodule
